@@ src/hsp_pkg.sv @@
// Shared types, operation codes and transaction layouts for the handle slot pool.
package hsp_pkg;

	localparam int unsigned SLOTS_DEF = 64;
	localparam int unsigned TDATA_W   = 208;
	localparam int unsigned HANDLE_W  = 6;

	typedef enum logic [3:0] {
		MODE_ALLOC      = 4'd0,
		MODE_FREE       = 4'd1,
		MODE_RESET      = 4'd2,
		MODE_VK_ERR     = 4'd3,
		MODE_INT_ERR    = 4'd4,
		MODE_SET_FENCE  = 4'd5,
		MODE_SET_STATUS = 4'd6,
		MODE_GET_STATUS = 4'd7,
		MODE_GET_FENCE  = 4'd8
	} mode_t;

	localparam logic [2:0] STATUS_ERROR  = 3'd1;
	localparam logic [1:0] KIND_VULKAN   = 2'd1;
	localparam logic [1:0] KIND_INTERNAL = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Input transaction, last field (mode) in the lowest bits.
	typedef struct packed {
		logic [2:0]          pad;
		logic [31:0]         fence_index;
		logic [63:0]         fence_gen;
		logic [63:0]         fence_handle;
		logic signed [31:0]  error_code;
		logic [2:0]          status_value;
		logic [HANDLE_W-1:0] handle;
		logic [3:0]          mode;
	} in_item_t;

	// Result transaction, last field (ok) in the lowest bits.
	typedef struct packed {
		logic [3:0]          pad;
		logic [31:0]         fence_index_out;
		logic [63:0]         fence_gen_out;
		logic [63:0]         fence_handle_out;
		logic signed [31:0]  error_code_out;
		logic [1:0]          error_kind;
		logic [2:0]          status_out;
		logic [HANDLE_W-1:0] handle_out;
		logic                ok;
	} out_item_t;

	// One slot entry as held in the slot memory.
	typedef struct packed {
		logic        valid;
		logic [2:0]  status;
		logic [1:0]  error_kind;
		logic [31:0] error_code;
		logic [63:0] fence_handle;
		logic [63:0] fence_gen;
		logic [31:0] fence_index;
	} slot_t;

	typedef struct packed {
		logic rd;
		logic pop;
		logic push;
	} stk_cmd_t;

endpackage

@@ src/handle_slot_pool.sv @@
// Handle slot pool: top level with operation sequencer and result register.
//
// Handle slot pool. After reset the block runs a clearing pass (ST_CLEAR) that zeroes
// every slot entry and fills the free stack with 0..SLOTS-1; s_tready stays low meanwhile.
// For each operation, the accept edge issues the slot memory read and the free-stack top
// read, and the edge that leaves ST_EXEC writes the slot back, moves the stack count and
// loads the result register. The slot memory read is registered.
// One operation is in flight at a time; a result waiting in the output register does not
// block acceptance of the next operation, but that operation stalls in ST_EXEC until the
// output register is taken. Allocation pops the most recently freed index, highest after reset.
module handle_slot_pool #(
	parameter int unsigned SLOTS = hsp_pkg::SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// mode, handle, status_value, error_code, fence_handle, fence_gen, fence_index
	input  logic [hsp_pkg::TDATA_W-1:0] s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// ok, handle_out, status_out, error_kind, error_code_out, fence_handle_out,
	// fence_gen_out, fence_index_out
	output logic [hsp_pkg::TDATA_W-1:0] m_tdata
);

	localparam int unsigned AW   = $clog2(SLOTS);
	localparam int unsigned CNTW = $clog2(SLOTS + 1);

	hsp_pkg::state_t    state_q, state_d;
	hsp_pkg::in_item_t  in_item, item_q;
	hsp_pkg::out_item_t res;
	hsp_pkg::slot_t     rd_slot, wr_slot;
	hsp_pkg::stk_cmd_t  stk_cmd;

	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   wr_addr;
	logic            wr_en;
	logic [AW-1:0]   top;
	logic [CNTW-1:0] count;
	logic            accept, fire, live, clearing;
	logic            m_tvalid_q;
	logic [hsp_pkg::TDATA_W-1:0] m_tdata_q;

	assign in_item  = hsp_pkg::in_item_t'(s_tdata);
	assign s_tready = (state_q == hsp_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign clearing = (state_q == hsp_pkg::ST_CLEAR);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// handle beyond the pool never matches an allocated slot
	assign live = (32'(item_q.handle) < 32'(SLOTS)) && rd_slot.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsp_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
	end

	always_comb begin
		state_d       = state_q;
		fire          = 1'b0;
		stk_cmd       = '0;
		stk_cmd.rd    = accept;
		wr_en         = 1'b0;
		wr_addr       = AW'(item_q.handle);
		wr_slot       = rd_slot;
		res           = '0;
		res.handle_out = item_q.handle;

		unique case (state_q)
			hsp_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_slot = '0;
				if (clr_q == AW'(SLOTS - 1)) begin
					state_d = hsp_pkg::ST_IDLE;
				end
			end
			hsp_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = hsp_pkg::ST_EXEC;
				end
			end
			hsp_pkg::ST_EXEC: begin
				fire = !m_tvalid_q || m_tready;
				unique case (hsp_pkg::mode_t'(item_q.mode))
					hsp_pkg::MODE_ALLOC: begin
						res.handle_out = '0;
						if (count != '0) begin
							res.ok         = 1'b1;
							res.handle_out = hsp_pkg::HANDLE_W'(top);
							stk_cmd.pop    = fire;
							wr_en          = fire;
							wr_addr        = top;
							// a free slot is always cleared, so only valid needs setting
							wr_slot        = '0;
							wr_slot.valid  = 1'b1;
						end
					end
					hsp_pkg::MODE_FREE: begin
						if (live && (count < CNTW'(SLOTS))) begin
							res.ok       = 1'b1;
							stk_cmd.push = fire;
							wr_en        = fire;
							wr_slot      = '0;
						end
					end
					hsp_pkg::MODE_RESET: begin
						if (live) begin
							res.ok        = 1'b1;
							wr_en         = fire;
							wr_slot       = '0;
							wr_slot.valid = 1'b1;
						end
					end
					hsp_pkg::MODE_VK_ERR, hsp_pkg::MODE_INT_ERR: begin
						if (live) begin
							res.ok             = 1'b1;
							wr_en              = fire;
							wr_slot.error_kind = (item_q.mode == hsp_pkg::MODE_VK_ERR) ?
								hsp_pkg::KIND_VULKAN : hsp_pkg::KIND_INTERNAL;
							wr_slot.error_code = item_q.error_code;
							wr_slot.status     = hsp_pkg::STATUS_ERROR;
						end
					end
					hsp_pkg::MODE_SET_FENCE: begin
						if (live) begin
							res.ok               = 1'b1;
							wr_en                = fire;
							wr_slot.fence_handle = item_q.fence_handle;
							wr_slot.fence_gen    = item_q.fence_gen;
							wr_slot.fence_index  = item_q.fence_index;
						end
					end
					hsp_pkg::MODE_SET_STATUS: begin
						if (live) begin
							res.ok         = 1'b1;
							wr_en          = fire;
							wr_slot.status = item_q.status_value;
						end
					end
					hsp_pkg::MODE_GET_STATUS: begin
						if (live) begin
							res.ok             = 1'b1;
							res.status_out     = rd_slot.status;
							res.error_kind     = rd_slot.error_kind;
							res.error_code_out = rd_slot.error_code;
						end
					end
					hsp_pkg::MODE_GET_FENCE: begin
						if (live) begin
							res.ok               = 1'b1;
							res.fence_handle_out = rd_slot.fence_handle;
							res.fence_gen_out    = rd_slot.fence_gen;
							res.fence_index_out  = rd_slot.fence_index;
						end
					end
					default: begin
					end
				endcase
				if (fire) begin
					state_d = hsp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hsp_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata_q <= res;
		end
	end

	hsp_slot_ram #(
		.SLOTS(SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (AW'(in_item.handle)),
		.rd_data (rd_slot),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_slot)
	);

	hsp_free_stack #(
		.SLOTS(SLOTS)
	) u_free_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (stk_cmd),
		.init_en  (clearing),
		.init_idx (clr_q),
		.push_idx (AW'(item_q.handle)),
		.top      (top),
		.count    (count)
	);

endmodule

@@ src/hsp_slot_ram.sv @@
// Slot memory: one slot entry per word, registered read port, one write port.
module hsp_slot_ram #(
	parameter int unsigned SLOTS = hsp_pkg::SLOTS_DEF,
	localparam int unsigned AW = $clog2(SLOTS)
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output hsp_pkg::slot_t  rd_data,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  hsp_pkg::slot_t  wr_data
);

	hsp_pkg::slot_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ src/hsp_free_stack.sv @@
// LIFO of free slot indices with its fill count; top of stack read is registered.
module hsp_free_stack #(
	parameter int unsigned SLOTS = hsp_pkg::SLOTS_DEF,
	localparam int unsigned AW   = $clog2(SLOTS),
	localparam int unsigned CNTW = $clog2(SLOTS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hsp_pkg::stk_cmd_t cmd,
	input  logic              init_en,
	input  logic [AW-1:0]     init_idx,
	input  logic [AW-1:0]     push_idx,
	output logic [AW-1:0]     top,
	output logic [CNTW-1:0]   count
);

	logic [AW-1:0]   mem [SLOTS];
	logic [CNTW-1:0] count_q;

	assign count = count_q;

	always_ff @(posedge clk) begin
		if (init_en) begin
			mem[init_idx] <= init_idx;
		end else if (cmd.push) begin
			mem[count_q[AW-1:0]] <= push_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			top <= mem[AW'(count_q - 1'b1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNTW'(SLOTS);
		end else if (cmd.pop) begin
			count_q <= count_q - 1'b1;
		end else if (cmd.push) begin
			count_q <= count_q + 1'b1;
		end
	end

endmodule

@@ src/hsp_checker.sv @@
// Port-level checks on the handle slot pool, bound to its top level.
module hsp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [hsp_pkg::TDATA_W-1:0] m_tdata
);

	hsp_pkg::out_item_t res;

	assign res = hsp_pkg::out_item_t'(m_tdata);

	// one operation in flight: no accept on the edge right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction accepted while one is in flight");

	// every accepted operation produces a result, registered after its execute state, unless output is blocked
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (!m_tvalid || m_tready) |=> ##1 m_tvalid)
		else $error("no result after accepted transaction");

	// a failed operation returns no stored data
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.ok |-> res.status_out == '0 && res.error_kind == '0 &&
			res.error_code_out == '0 && res.fence_handle_out == '0 &&
			res.fence_gen_out == '0 && res.fence_index_out == '0)
		else $error("failed result carries slot data");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind handle_slot_pool hsp_checker u_hsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
